@@ rtl/avt_pkg.sv @@
// Package for the affine vertex transform core: item structs, register map,
// reset values and arithmetic sizes. No dependencies.
`default_nettype none

package avt_pkg;

  localparam int DefFracBits = 16;
  localparam int CoefW       = 32;
  localparam int ProdW       = 2 * CoefW;
  // four full products plus the rounding term fit in two extra bits
  localparam int AccW        = ProdW + 2;
  localparam int NumRows     = 3;
  localparam int NumTerms    = 4;
  localparam int NumRegs     = 6;
  localparam int RegW        = 64;
  localparam int RegIdxW     = 3;
  localparam int PaddrW      = 6;

  localparam logic [RegIdxW-1:0] REG_ROW_X_FIRST  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ROW_X_SECOND = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ROW_Y_FIRST  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ROW_Y_SECOND = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ROW_Z_FIRST  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ROW_Z_SECOND = 3'd5;

  // identity matrix, zero translation
  localparam logic [RegW-1:0] RST_ROW_X_FIRST  = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] RST_ROW_X_SECOND = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] RST_ROW_Y_FIRST  = 64'h0001_0000_0000_0000;
  localparam logic [RegW-1:0] RST_ROW_Y_SECOND = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] RST_ROW_Z_FIRST  = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] RST_ROW_Z_SECOND = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
  } vtx_out_t;

endpackage

`default_nettype wire

@@ rtl/affine_vertex_transform_core.sv @@
// Affine vertex transform core: 3x4 matrix times (x, y, z, w) in signed
// fixed point, three-stage pipeline with an APB register port.
// Depends on avt_pkg.
//
//   channel   handshake                   payload
//   in        in_valid / in_stall         in_data   (vtx_in_t)
//   out       out_valid / out_stall       out_data  (vtx_out_t)
//   config    psel/penable/pwrite/pready  paddr, pwdata, prdata (64 bit)
//
// One item per cycle sustained while out_stall is low; registered stages:
// the twelve 32x32 products, row sums with rounding term, then shift/clamp.
// Each stage takes new data whenever it is empty or the stage after it moves,
// so bubbles are squeezed out and a stalled output still lets earlier stages
// fill. Reset clears the valid bits and loads the identity matrix.
`default_nettype none

module affine_vertex_transform_core
  import avt_pkg::*;
#(
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire vtx_in_t           in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      vtx_out_t          out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [RegW-1:0]   pwdata,
  output      logic [RegW-1:0]   prdata,
  output      logic              pready
);

  localparam logic signed [AccW-1:0] Rnd = AccW'((1 << FRAC_BITS) >> 1);

  // ---------------- configuration registers ----------------
  logic [RegW-1:0]    coef [NumRegs];
  logic [RegIdxW-1:0] widx;

  assign widx   = paddr[PaddrW-1 -: RegIdxW];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_ROW_X_FIRST]  <= RST_ROW_X_FIRST;
      coef[REG_ROW_X_SECOND] <= RST_ROW_X_SECOND;
      coef[REG_ROW_Y_FIRST]  <= RST_ROW_Y_FIRST;
      coef[REG_ROW_Y_SECOND] <= RST_ROW_Y_SECOND;
      coef[REG_ROW_Z_FIRST]  <= RST_ROW_Z_FIRST;
      coef[REG_ROW_Z_SECOND] <= RST_ROW_Z_SECOND;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_ROW_X_FIRST:  coef[REG_ROW_X_FIRST]  <= pwdata;
        REG_ROW_X_SECOND: coef[REG_ROW_X_SECOND] <= pwdata;
        REG_ROW_Y_FIRST:  coef[REG_ROW_Y_FIRST]  <= pwdata;
        REG_ROW_Y_SECOND: coef[REG_ROW_Y_SECOND] <= pwdata;
        REG_ROW_Z_FIRST:  coef[REG_ROW_Z_FIRST]  <= pwdata;
        REG_ROW_Z_SECOND: coef[REG_ROW_Z_SECOND] <= pwdata;
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ROW_X_FIRST:  prdata = coef[REG_ROW_X_FIRST];
      REG_ROW_X_SECOND: prdata = coef[REG_ROW_X_SECOND];
      REG_ROW_Y_FIRST:  prdata = coef[REG_ROW_Y_FIRST];
      REG_ROW_Y_SECOND: prdata = coef[REG_ROW_Y_SECOND];
      REG_ROW_Z_FIRST:  prdata = coef[REG_ROW_Z_FIRST];
      REG_ROW_Z_SECOND: prdata = coef[REG_ROW_Z_SECOND];
      default:          prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---------------- stage 1: products ----------------
  logic signed [CoefW-1:0] cf [NumRows][NumTerms];
  logic signed [CoefW-1:0] vin [NumTerms];
  logic signed [ProdW-1:0] prod [NumRows][NumTerms];
  logic signed [CoefW-1:0] w1, w2;

  assign vin[0] = in_data.in_x;
  assign vin[1] = in_data.in_y;
  assign vin[2] = in_data.in_z;
  assign vin[3] = in_data.in_w;

  // row r uses registers 2r (x, y) and 2r+1 (z, translation)
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      cf[r][0] = signed'(coef[2*r][CoefW-1:0]);
      cf[r][1] = signed'(coef[2*r][RegW-1:CoefW]);
      cf[r][2] = signed'(coef[2*r+1][CoefW-1:0]);
      cf[r][3] = signed'(coef[2*r+1][RegW-1:CoefW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int t = 0; t < NumTerms; t++) begin
          prod[r][t] <= ProdW'(cf[r][t]) * ProdW'(vin[t]);
        end
      end
      w1 <= in_data.in_w;
    end
  end

  // ---------------- stage 2: row sums plus rounding term ----------------
  logic signed [AccW-1:0] acc_next [NumRows];
  logic signed [AccW-1:0] acc [NumRows];

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      acc_next[r] = AccW'(prod[r][0]) + AccW'(prod[r][1])
                  + AccW'(prod[r][2]) + AccW'(prod[r][3]) + Rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < NumRows; r++) begin
        acc[r] <= acc_next[r];
      end
      w2 <= w1;
    end
  end

  // ---------------- stage 3: shift and clamp ----------------
  logic signed [AccW-1:0]  shifted [NumRows];
  logic        [NumRows-1:0] clip;
  logic signed [CoefW-1:0] res [NumRows];

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      shifted[r] = acc[r] >>> FRAC_BITS;
      // in range when every bit above bit 31 equals bit 31
      clip[r] = !((&shifted[r][AccW-1:CoefW-1]) || !(|shifted[r][AccW-1:CoefW-1]));
      if (clip[r]) begin
        res[r] = shifted[r][AccW-1] ? signed'(32'h8000_0000) : signed'(32'h7FFF_FFFF);
      end else begin
        res[r] = shifted[r][CoefW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_data.out_x     <= res[0];
      out_data.out_y     <= res[1];
      out_data.out_z     <= res[2];
      out_data.out_w     <= w2;
      out_data.saturated <= |clip;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for affine_vertex_transform_core: random valid/stall
// traffic on both item channels, APB matrix loads, and a fixed-point predictor.
// Depends on avt_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import avt_pkg::*;

  localparam int FracBits = DefFracBits;
  localparam logic signed [127:0] RoundBias =
    (FracBits > 0) ? (128'sd1 <<< ((FracBits > 0) ? FracBits - 1 : 0)) : 128'sd0;
  localparam logic signed [31:0] SatHi = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatLo = 32'sh8000_0000;
  localparam int IdlePct = 27;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  vtx_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vtx_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [RegW-1:0]   pwdata = '0;
  logic [RegW-1:0]   prdata;
  logic              pready;

  // mirror of the matrix registers, only changed while the core is idle
  logic [RegW-1:0] matrix_regs [NumRegs];
  vtx_in_t         vtx_pending[$];
  vtx_out_t        xform_expected[$];
  logic            calm = 1'b0;
  int              errors = 0;
  int              n_checked = 0;
  int              n_sat = 0;
  int              n_settings = 0;

  affine_vertex_transform_core #(.FRAC_BITS(FracBits)) u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [127:0] wide(input logic signed [31:0] v);
    return v;
  endfunction

  // {clamped, value} for one matrix row
  function automatic logic [32:0] row_dot(input logic [RegW-1:0] first,
                                          input logic [RegW-1:0] second,
                                          input vtx_in_t v);
    logic signed [127:0] acc;
    acc = wide(first[31:0]) * wide(v.in_x) + wide(first[63:32]) * wide(v.in_y) +
          wide(second[31:0]) * wide(v.in_z) + wide(second[63:32]) * wide(v.in_w);
    acc = (acc + RoundBias) >>> FracBits;
    if (acc > wide(SatHi)) return {1'b1, SatHi};
    if (acc < wide(SatLo)) return {1'b1, SatLo};
    return {1'b0, acc[31:0]};
  endfunction

  function automatic vtx_out_t transform_vertex(input vtx_in_t v);
    vtx_out_t    o;
    logic [32:0] rx, ry, rz;
    rx = row_dot(matrix_regs[REG_ROW_X_FIRST], matrix_regs[REG_ROW_X_SECOND], v);
    ry = row_dot(matrix_regs[REG_ROW_Y_FIRST], matrix_regs[REG_ROW_Y_SECOND], v);
    rz = row_dot(matrix_regs[REG_ROW_Z_FIRST], matrix_regs[REG_ROW_Z_SECOND], v);
    o.out_x     = rx[31:0];
    o.out_y     = ry[31:0];
    o.out_z     = rz[31:0];
    o.out_w     = v.in_w;
    o.saturated = rx[32] | ry[32] | rz[32];
    return o;
  endfunction

  function automatic vtx_in_t vtx(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [31:0] w);
    vtx_in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  // mix of corner values, values within +/-span, and full-range words
  function automatic logic [31:0] rand_word(input logic [31:0] span);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(0, 2 * span - 1) - span;
      default: return $urandom;
    endcase
  endfunction

  // driver: a new item goes out only when the current one has been taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) xform_expected.push_back(transform_vertex(in_data));
      if (!in_valid || !in_stall) begin
        if (vtx_pending.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_data  <= vtx_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    vtx_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (xform_expected.size() == 0) begin
          $display("%0t: unexpected item: x=%h y=%h z=%h w=%h sat=%b", $time,
                   out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_w,
                   out_data.saturated);
          errors++;
        end else begin
          want = xform_expected.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.out_z !== want.out_z || out_data.out_w !== want.out_w ||
              out_data.saturated !== want.saturated) begin
            $display("%0t: mismatch: expected x=%h y=%h z=%h w=%h sat=%b", $time,
                     want.out_x, want.out_y, want.out_z, want.out_w, want.saturated);
            $display("%0t:           actual   x=%h y=%h z=%h w=%h sat=%b", $time,
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_w,
                     out_data.saturated);
            errors++;
          end
          n_checked++;
          if (want.saturated) n_sat++;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  task automatic apb_xfer(input int idx, input logic wr, input logic [RegW-1:0] wdata,
                          output logic [RegW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PaddrW'(idx * 8);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // indexes past the last register must be ignored by the core
  task automatic reg_write(input int idx, input logic [RegW-1:0] val);
    logic [RegW-1:0] rd;
    apb_xfer(idx, 1'b1, val, rd);
    if (idx < NumRegs) begin
      matrix_regs[idx] = val;
      apb_xfer(idx, 1'b0, '0, rd);
      if (rd !== val) begin
        $display("%0t: register %0d readback: expected %h actual %h", $time, idx, val, rd);
        errors++;
      end
    end
  endtask

  task automatic load_matrix(input logic [NumRegs-1:0][RegW-1:0] m);
    for (int i = 0; i < NumRegs; i++) reg_write(i, m[i]);
    n_settings++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (vtx_pending.size() != 0 || in_valid || xform_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic rand_batch(input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++)
      vtx_pending.push_back(vtx(rand_word(32'h0010_0000), rand_word(32'h0010_0000),
                                rand_word(32'h0010_0000), rand_word(32'h0010_0000)));
    drain();
  endtask

  initial begin
    logic [NumRegs-1:0][RegW-1:0] m;
    matrix_regs[REG_ROW_X_FIRST]  = RST_ROW_X_FIRST;
    matrix_regs[REG_ROW_X_SECOND] = RST_ROW_X_SECOND;
    matrix_regs[REG_ROW_Y_FIRST]  = RST_ROW_Y_FIRST;
    matrix_regs[REG_ROW_Y_SECOND] = RST_ROW_Y_SECOND;
    matrix_regs[REG_ROW_Z_FIRST]  = RST_ROW_Z_FIRST;
    matrix_regs[REG_ROW_Z_SECOND] = RST_ROW_Z_SECOND;
    n_settings = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // identity from reset: input extremes come through unchanged
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h0, 32'h0, 32'h0, 32'h0));
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    vtx_pending.push_back(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
    vtx_pending.push_back(vtx(32'h0001_8000, 32'hFFFE_8000, 32'h5555_AAAA, 32'hAAAA_5555));
    drain();

    // half coefficients put products exactly on rounding ties
    m = '0;
    m[REG_ROW_X_FIRST]  = 64'h0000_0000_0000_8000;
    m[REG_ROW_Y_FIRST]  = 64'hFFFF_8000_0000_0000;
    m[REG_ROW_Z_SECOND] = 64'h0000_8000_0000_0000;
    load_matrix(m);
    reg_write(NumRegs, '1);
    reg_write(NumRegs + 1, 64'h1234_5678_9ABC_DEF0);
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h1, 32'h1, 32'h0, 32'h1));
    vtx_pending.push_back(vtx(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    vtx_pending.push_back(vtx(32'h3, 32'h3, 32'h0, 32'h3));
    vtx_pending.push_back(vtx(32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'h0, 32'hFFFF_FFFD));
    vtx_pending.push_back(vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
    drain();

    // largest positive coefficients: clamps in both directions
    load_matrix({NumRegs{64'h7FFF_FFFF_7FFF_FFFF}});
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    vtx_pending.push_back(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'h1, 32'h0, 32'h0, 32'h0));
    vtx_pending.push_back(vtx(32'h0, 32'h0, 32'h0, 32'h0));
    drain();

    // most negative coefficients: min * min * 4 is the largest sum there is
    load_matrix({NumRegs{64'h8000_0000_8000_0000}});
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    vtx_pending.push_back(vtx(32'h1, 32'h1, 32'h1, 32'h1));
    drain();

    load_matrix({NumRegs{64'hFFFF_FFFF_FFFF_FFFF}});
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'h1, 32'h1, 32'h1, 32'h1));
    vtx_pending.push_back(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain();

    load_matrix('0);
    @(negedge clk);
    vtx_pending.push_back(vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000));
    vtx_pending.push_back(vtx(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    // random matrices; the third batch runs with no idling on either side
    for (int b = 0; b < 5; b++) begin
      for (int i = 0; i < NumRegs; i++)
        m[i] = {rand_word(32'h0004_0000), rand_word(32'h0004_0000)};
      load_matrix(m);
      if (b == 2) begin
        @(posedge clk);
        calm <= 1'b1;
      end
      rand_batch(200);
      if (b == 2) begin
        @(posedge clk);
        calm <= 1'b0;
      end
    end

    repeat (20) @(posedge clk);
    if (xform_expected.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, xform_expected.size());
      errors++;
    end
    $display("Checked %0d transformed vertices under %0d matrix settings, %0d clamped.",
             n_checked, n_settings, n_sat);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
